@@ hdl/bisv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisv_pkg
// Shared constants, types and the divide-by-5 helper for the button face
// variant pipeline.
// ----------------------------------------------------------------------------
package bisv_pkg;

    // number of register stages in the datapath
    localparam int NSTAGE = 4;

    // gray targets of the opaque disabled variants
    localparam logic [10:0] TW_DIS_BASE = 11'(3 * 216);
    localparam logic [10:0] TW_DCL_BASE = 11'(3 * 188);

    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    // floor(x/5) as x*1639 >> 13, exact for x < 2730
    localparam logic [21:0] DIV5_MUL   = 22'd1639;
    localparam int          DIV5_SHIFT = 13;

    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
        logic [NSTAGE-1:0] valid;
    } pipe_ctl_t;

    function automatic logic [8:0] div5(input logic [10:0] x);
        logic [21:0] prod;
        prod = 22'(x) * DIV5_MUL;
        return prod[DIV5_SHIFT+8:DIV5_SHIFT];
    endfunction

endpackage

@@ hdl/button_icon_state_variants.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_icon_state_variants
// Derives normal, clicked, disabled and disabled-clicked button faces from
// one source pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one pixel per beat (three color bytes and alpha).
//   Output channel m_*: one beat per input beat, four packed 32-bit pixels,
//   byte k in bits 8k+7..8k, alpha in the top byte.
//   cfg_wr_en/cfg_wr_data write alpha_mode (0 opaque, 1 per-pixel alpha);
//   write it only while the pipe is empty.
// Pipeline: four datapath stages (numerators, divide by 5, desaturate, darken
//   and pack). The accept edge loads stage 1; the beat then passes through
//   stages 2, 3 and 4, and m_valid rises once stage 4 holds it.
// Throughput: one pixel per cycle while m_ready is high; a stage holds one pixel.
// Stall: when m_ready is low the output stage holds its beat; earlier stages
//   keep filling until every stage is full, then s_ready drops. Nothing is
//   dropped or repeated.
// Reset (aresetn low, synchronous): all valid bits clear and alpha_mode
//   returns to opaque.
// ----------------------------------------------------------------------------
module button_icon_state_variants (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_chan0,
    input  logic [7:0]  s_chan1,
    input  logic [7:0]  s_chan2,
    input  logic [7:0]  s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_normal_pixel,
    output logic [31:0] m_clicked_pixel,
    output logic [31:0] m_disabled_pixel,
    output logic [31:0] m_disabled_clicked_pixel
);

    bisv_pkg::pipe_ctl_t ctl;

    logic alpha_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            alpha_mode_reg <= cfg_wr_data;
        end
    end

    bisv_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // ---------------- stage 1: numerators ----------------
    // mode travels with the beat so each pixel uses the mode it entered with
    bisv_pkg::rgb_t         s1_c_reg;
    logic [7:0]             s1_a_reg;
    logic                   s1_mode_reg;
    logic [2:0][10:0]       s1_n4c_reg;    // 4c
    logic [2:0][10:0]       s1_ndis_reg;   // 3*216 + 2c
    logic [2:0][10:0]       s1_ndcl_reg;   // 3*188 + 2c
    logic [11:0]            s1_gsum_reg;   // c0 + 6c1 + 3c2 (= 10x gray sum / 10)
    logic [9:0]             s1_n3a_reg;    // 3a

    bisv_pkg::rgb_t         s1_c_next;
    logic [2:0][10:0]       s1_n4c_next;
    logic [2:0][10:0]       s1_ndis_next;
    logic [2:0][10:0]       s1_ndcl_next;
    logic [11:0]            s1_gsum_next;
    logic [9:0]             s1_n3a_next;

    always_comb begin
        s1_c_next = {s_chan2, s_chan1, s_chan0};
        for (int i = 0; i < 3; i++) begin
            s1_n4c_next[i]  = {1'b0, s1_c_next[i], 2'b00};
            s1_ndis_next[i] = bisv_pkg::TW_DIS_BASE + {2'b00, s1_c_next[i], 1'b0};
            s1_ndcl_next[i] = bisv_pkg::TW_DCL_BASE + {2'b00, s1_c_next[i], 1'b0};
        end
        s1_gsum_next = 12'(s_chan0) + 12'(s_chan1) * 12'd6 + 12'(s_chan2) * 12'd3;
        s1_n3a_next  = 10'(s_alpha_in) * 10'd3;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            s1_c_reg    <= s1_c_next;
            s1_a_reg    <= s_alpha_in;
            s1_mode_reg <= alpha_mode_reg;
            s1_n4c_reg  <= s1_n4c_next;
            s1_ndis_reg <= s1_ndis_next;
            s1_ndcl_reg <= s1_ndcl_next;
            s1_gsum_reg <= s1_gsum_next;
            s1_n3a_reg  <= s1_n3a_next;
        end
    end

    // ---------------- stage 2: divide by 5 ----------------
    // floor(s/10) = floor(floor(s/2)/5)
    bisv_pkg::rgb_t s2_c_reg, s2_k_reg, s2_dis_reg, s2_dcl_reg;
    logic [7:0]     s2_a_reg, s2_gray_reg, s2_da_reg;
    logic           s2_mode_reg;

    bisv_pkg::rgb_t s2_k_next, s2_dis_next, s2_dcl_next;
    logic [8:0]     s2_gray_q, s2_da_q;
    logic [2:0][8:0] s2_k_q, s2_dis_q, s2_dcl_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_k_q[i]      = bisv_pkg::div5(s1_n4c_reg[i]);
            s2_dis_q[i]    = bisv_pkg::div5(s1_ndis_reg[i]);
            s2_dcl_q[i]    = bisv_pkg::div5(s1_ndcl_reg[i]);
            s2_k_next[i]   = s2_k_q[i][7:0];
            s2_dis_next[i] = s2_dis_q[i][7:0];
            s2_dcl_next[i] = s2_dcl_q[i][7:0];
        end
        s2_gray_q = bisv_pkg::div5(s1_gsum_reg[11:1]);
        s2_da_q   = bisv_pkg::div5({2'b00, s1_n3a_reg[9:1]});
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            s2_c_reg    <= s1_c_reg;
            s2_a_reg    <= s1_a_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_k_reg    <= s2_k_next;
            s2_dis_reg  <= s2_dis_next;
            s2_dcl_reg  <= s2_dcl_next;
            s2_gray_reg <= s2_gray_q[7:0];
            s2_da_reg   <= s2_da_q[7:0];
        end
    end

    // ---------------- stage 3: desaturate ----------------
    // d = floor((7*gray + 3c) / 10)
    bisv_pkg::rgb_t s3_c_reg, s3_k_reg, s3_dis_reg, s3_dcl_reg, s3_dv_reg;
    logic [7:0]     s3_a_reg, s3_da_reg;
    logic           s3_mode_reg;

    logic [2:0][11:0] s3_num;
    logic [2:0][8:0]  s3_dv_q;
    bisv_pkg::rgb_t   s3_dv_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_num[i]     = 12'(s2_gray_reg) * 12'd7 + 12'(s2_c_reg[i]) * 12'd3;
            s3_dv_q[i]    = bisv_pkg::div5(s3_num[i][11:1]);
            s3_dv_next[i] = s3_dv_q[i][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            s3_c_reg    <= s2_c_reg;
            s3_a_reg    <= s2_a_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_k_reg    <= s2_k_reg;
            s3_dis_reg  <= s2_dis_reg;
            s3_dcl_reg  <= s2_dcl_reg;
            s3_da_reg   <= s2_da_reg;
            s3_dv_reg   <= s3_dv_next;
        end
    end

    // ---------------- stage 4: darken disabled, select and pack ----------------
    logic [31:0] out_n_reg, out_k_reg, out_d_reg, out_dc_reg;
    logic [31:0] out_n_next, out_k_next, out_d_next, out_dc_next;
    logic [2:0][8:0] s4_dk_q;
    bisv_pkg::rgb_t  s4_dk;
    logic [7:0]      s4_alpha;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_dk_q[i] = bisv_pkg::div5({1'b0, s3_dv_reg[i], 2'b00});
            s4_dk[i]   = s4_dk_q[i][7:0];
        end
        s4_alpha   = s3_mode_reg ? s3_a_reg : bisv_pkg::OPAQUE_ALPHA;
        out_n_next = {s4_alpha, s3_c_reg};
        out_k_next = {s4_alpha, s3_k_reg};
        if (s3_mode_reg) begin
            out_d_next  = {s3_da_reg, s3_dv_reg};
            out_dc_next = {s3_da_reg, s4_dk};
        end else begin
            out_d_next  = {bisv_pkg::OPAQUE_ALPHA, s3_dis_reg};
            out_dc_next = {bisv_pkg::OPAQUE_ALPHA, s3_dcl_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            out_n_reg  <= out_n_next;
            out_k_reg  <= out_k_next;
            out_d_reg  <= out_d_next;
            out_dc_reg <= out_dc_next;
        end
    end

    assign m_valid                  = ctl.valid[bisv_pkg::NSTAGE-1];
    assign m_normal_pixel           = out_n_reg;
    assign m_clicked_pixel          = out_k_reg;
    assign m_disabled_pixel         = out_d_reg;
    assign m_disabled_clicked_pixel = out_dc_reg;

endmodule

@@ hdl/bisv_pipe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisv_pipe_ctrl
// Valid bits and per-stage load enables; a stage advances when it is empty
// or when the stage after it advances.
// ----------------------------------------------------------------------------
module bisv_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                m_ready,
    output bisv_pkg::pipe_ctl_t ctl
);

    logic [bisv_pkg::NSTAGE-1:0] valid_reg;
    logic [bisv_pkg::NSTAGE-1:0] valid_next;
    logic [bisv_pkg::NSTAGE:0]   rdy;
    logic [bisv_pkg::NSTAGE-1:0] feed;

    always_comb begin
        rdy[bisv_pkg::NSTAGE] = m_ready;
        for (int i = bisv_pkg::NSTAGE - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        feed = {valid_reg[bisv_pkg::NSTAGE-2:0], s_valid};
        for (int i = 0; i < bisv_pkg::NSTAGE; i++) begin
            valid_next[i] = rdy[i] ? feed[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready   = rdy[0];
    assign ctl.load  = rdy[bisv_pkg::NSTAGE-1:0];
    assign ctl.valid = valid_reg;

endmodule

@@ hdl/bisv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisv_checker
// Port-level checks for the button face variant pipeline.
// ----------------------------------------------------------------------------
module bisv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_normal_pixel,
    input logic [31:0] m_clicked_pixel,
    input logic [31:0] m_disabled_pixel,
    input logic [31:0] m_disabled_clicked_pixel
);

    // output beat held while stalled: m_valid and the disabled-clicked pixel
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped during stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_disabled_clicked_pixel))
        else $error("output changed during stall");

    // reset empties the pipe
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // normal and clicked share alpha; disabled pair shares alpha
    a_alpha_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_pixel[31:24] == m_clicked_pixel[31:24]) &&
                    (m_disabled_pixel[31:24] == m_disabled_clicked_pixel[31:24]))
        else $error("alpha mismatch between variants");

    // clicked never brighter than normal
    a_clicked_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_clicked_pixel[7:0] <= m_normal_pixel[7:0]) &&
                    (m_clicked_pixel[15:8] <= m_normal_pixel[15:8]) &&
                    (m_clicked_pixel[23:16] <= m_normal_pixel[23:16]))
        else $error("clicked brighter than normal");

endmodule

bind button_icon_state_variants bisv_checker u_bisv_checker (.*);
